/* hw/rtl/dcs_pkg.sv */
package dcs_pkg;

	typedef struct packed {
		logic signed [31:0] y;
		logic signed [31:0] x;
	} point_t;

	typedef struct packed {
		logic shift;
		logic mul;
		logic acc;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_EMIT
	} state_t;

	localparam logic REG_T_FRAC = 1'b0;
	localparam logic REG_STAGE  = 1'b1;

	localparam int STAGE_W = 6;

endpackage

/* hw/rtl/dcs_pt_if.sv */
interface dcs_pt_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] px;
	logic signed [31:0] py;
	logic               point_last;

	modport source (output valid, output px, output py, output point_last, input ready);
	modport sink (input valid, input px, input py, input point_last, output ready);
endinterface

/* hw/rtl/dcs_res_if.sv */
interface dcs_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] qx;
	logic signed [31:0] qy;
	logic               result_last;
	logic               empty_stage;
	logic               truncated;

	modport source (output valid, output qx, output qy, output result_last,
		output empty_stage, output truncated, input ready);
	modport sink (input valid, input qx, input qy, input result_last,
		input empty_stage, input truncated, output ready);
endinterface

/* hw/rtl/de_casteljau_stage_points.sv */
// channel | dir | word
// pts     | in  | px, py, point_last
// res     | out | qx, qy, result_last, empty_stage, truncated
// apb     | in  | t_frac at 0x0, stage_level at 0x4
//
// a point that yields a stage point runs k stages: each stage is a multiply
// step and then an add step in every cell of the row
// other points go straight back to idle or pass through emit; one item in flight at a time
// a finished word waits in the output register while the next point is taken
// reset clears control, the point count and the config registers; the point row and output word are not cleared
module de_casteljau_stage_points #(
	parameter int MAX_POINTS  = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	dcs_pt_if.sink      pts,
	dcs_res_if.source   res
);
	localparam int TW = T_FRAC_BITS + 1;
	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [TW-1:0]               t_frac;
	logic [dcs_pkg::STAGE_W-1:0] stage_level;

	dcs_pkg::state_t    state_q;
	dcs_pkg::state_t    state_d;
	dcs_pkg::cell_ctl_t ctl;
	dcs_pkg::point_t    in_pt;
	dcs_pkg::point_t    store_w [MAX_POINTS];
	dcs_pkg::point_t    work_w [MAX_POINTS];

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [IW-1:0] lvl_q;
	logic [IW-1:0] sel_q;
	logic          zero_q;
	logic          last_q;
	logic          empty_q;
	logic          trunc_q;

	logic signed [31:0] qx_q;
	logic signed [31:0] qy_q;
	logic               rlast_q;
	logic               rempty_q;
	logic               rtrunc_q;
	logic               out_valid_q;

	logic accept;
	logic full;
	logic deep_full;
	logic reach;
	logic out_free;
	logic emit_go;

	dcs_regs #(.T_FRAC_BITS(T_FRAC_BITS)) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.t_frac      (t_frac),
		.stage_level (stage_level)
	);

	always_comb begin
		in_pt.x = pts.px;
		in_pt.y = pts.py;
	end

	for (genvar c = 0; c < MAX_POINTS; c++) begin : g_cell
		dcs_pkg::point_t sh_in;
		dcs_pkg::point_t nb_in;
		if (c == 0) begin : g_head
			assign sh_in = in_pt;
			assign nb_in = '0;
		end else begin : g_body
			assign sh_in = store_w[c-1];
			assign nb_in = work_w[c-1];
		end
		dcs_cell #(.T_FRAC_BITS(T_FRAC_BITS)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.t        (t_frac),
			.shift_in (sh_in),
			.nbr      (nb_in),
			.store_o  (store_w[c]),
			.work_o   (work_w[c])
		);
	end

	assign pts.ready = (state_q == dcs_pkg::ST_IDLE);
	assign accept    = pts.valid && pts.ready;
	assign full      = (count_q == CW'(MAX_POINTS));
	assign deep_full = (8'(MAX_POINTS) <= 8'(stage_level));
	assign reach     = (8'(count_q) >= 8'(stage_level));
	assign out_free  = !out_valid_q || res.ready;
	assign emit_go   = (state_q == dcs_pkg::ST_EMIT) && out_free;

	always_comb begin
		ctl.shift = accept && !full;
		ctl.mul   = (state_q == dcs_pkg::ST_MUL);
		ctl.acc   = (state_q == dcs_pkg::ST_ACC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dcs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dcs_pkg::ST_IDLE: begin
				if (accept) begin
					if (full) begin
						if (pts.point_last)
							state_d = dcs_pkg::ST_EMIT;
					end else if (reach) begin
						if (stage_level == '0)
							state_d = dcs_pkg::ST_EMIT;
						else
							state_d = dcs_pkg::ST_MUL;
					end else if (pts.point_last) begin
						state_d = dcs_pkg::ST_EMIT;
					end
				end
			end
			dcs_pkg::ST_MUL: state_d = dcs_pkg::ST_ACC;
			dcs_pkg::ST_ACC: begin
				if (lvl_q == IW'(1))
					state_d = dcs_pkg::ST_EMIT;
				else
					state_d = dcs_pkg::ST_MUL;
			end
			dcs_pkg::ST_EMIT: begin
				if (out_free)
					state_d = dcs_pkg::ST_IDLE;
			end
			default: state_d = dcs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (pts.point_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// word meta taken at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			if (full) begin
				zero_q  <= 1'b1;
				last_q  <= 1'b1;
				empty_q <= deep_full;
				trunc_q <= 1'b1;
			end else begin
				zero_q  <= !reach;
				last_q  <= pts.point_last;
				empty_q <= !reach;
				trunc_q <= ovf_q;
			end
			sel_q <= stage_level[IW-1:0];
			lvl_q <= stage_level[IW-1:0];
		end else if (state_q == dcs_pkg::ST_ACC) begin
			lvl_q <= lvl_q - IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			qx_q     <= zero_q ? '0 : work_w[sel_q].x;
			qy_q     <= zero_q ? '0 : work_w[sel_q].y;
			rlast_q  <= last_q;
			rempty_q <= empty_q;
			rtrunc_q <= trunc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_go)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	assign res.valid       = out_valid_q;
	assign res.qx          = qx_q;
	assign res.qy          = qy_q;
	assign res.result_last = rlast_q;
	assign res.empty_stage = rempty_q;
	assign res.truncated   = rtrunc_q;

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == dcs_pkg::ST_EMIT))
		else $error("word loaded outside emit");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count past capacity");

	a_lvl_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dcs_pkg::ST_MUL) |-> (lvl_q != '0))
		else $error("stage counter empty while interpolating");

	a_set_close: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pts.point_last) |=> (count_q == '0 && !ovf_q))
		else $error("set not closed after last point");
endmodule

/* hw/rtl/dcs_regs.sv */
module dcs_regs #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output logic [T_FRAC_BITS:0]   t_frac,
	output logic [dcs_pkg::STAGE_W-1:0] stage_level
);
	localparam int TW = T_FRAC_BITS + 1;

	logic [TW-1:0]               t_frac_q;
	logic [dcs_pkg::STAGE_W-1:0] stage_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_frac_q <= '0;
			stage_q  <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				dcs_pkg::REG_T_FRAC: t_frac_q <= pwdata[TW-1:0];
				dcs_pkg::REG_STAGE:  stage_q  <= pwdata[dcs_pkg::STAGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			dcs_pkg::REG_T_FRAC: prdata = 32'(t_frac_q);
			dcs_pkg::REG_STAGE:  prdata = 32'(stage_q);
			default:             prdata = '0;
		endcase
	end

	assign t_frac      = t_frac_q;
	assign stage_level = stage_q;
endmodule

/* hw/rtl/dcs_cell.sv */
module dcs_cell #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic                clk,
	input  dcs_pkg::cell_ctl_t  ctl,
	input  logic [T_FRAC_BITS:0] t,
	input  dcs_pkg::point_t     shift_in,
	input  dcs_pkg::point_t     nbr,
	output dcs_pkg::point_t     store_o,
	output dcs_pkg::point_t     work_o
);
	localparam int PW = 34 + T_FRAC_BITS;

	dcs_pkg::point_t       store_q;
	dcs_pkg::point_t       work_q;
	logic signed [PW-1:0]  prod_x_q;
	logic signed [PW-1:0]  prod_y_q;
	logic signed [32:0]    dx;
	logic signed [32:0]    dy;
	logic signed [PW-1:0]  prod_x;
	logic signed [PW-1:0]  prod_y;
	logic signed [PW-1:0]  shx;
	logic signed [PW-1:0]  shy;
	logic [PW-1:0]         sum_x;
	logic [PW-1:0]         sum_y;
	dcs_pkg::point_t       lerp;

	function automatic logic [31:0] sat32(input logic [PW-1:0] v);
		logic in_range;
		begin
			in_range = (v[PW-1:31] == '0) || (v[PW-1:31] == '1);
			if (in_range)
				sat32 = v[31:0];
			else if (v[PW-1])
				sat32 = 32'h8000_0000;
			else
				sat32 = 32'h7fff_ffff;
		end
	endfunction

	// b - a times t, then a + floor(p / 2^T) with saturation
	always_comb begin
		dx     = {nbr.x[31], nbr.x} - {work_q.x[31], work_q.x};
		dy     = {nbr.y[31], nbr.y} - {work_q.y[31], work_q.y};
		prod_x = dx * $signed({1'b0, t});
		prod_y = dy * $signed({1'b0, t});
		shx    = prod_x_q >>> T_FRAC_BITS;
		shy    = prod_y_q >>> T_FRAC_BITS;
		sum_x  = shx + {{(PW-32){work_q.x[31]}}, work_q.x};
		sum_y  = shy + {{(PW-32){work_q.y[31]}}, work_q.y};
		lerp.x = sat32(sum_x);
		lerp.y = sat32(sum_y);
	end

	always_ff @(posedge clk) begin
		if (ctl.shift)
			store_q <= shift_in;
		if (ctl.shift)
			work_q <= shift_in;
		else if (ctl.acc)
			work_q <= lerp;
		if (ctl.mul) begin
			prod_x_q <= prod_x;
			prod_y_q <= prod_y;
		end
	end

	assign store_o = store_q;
	assign work_o  = work_q;
endmodule

/* dv/de_casteljau_stage_points_test.sv */
module de_casteljau_stage_points_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 16;
	localparam int T_BITS = 16;
	localparam int ITEM_TARGET = 1950;
	localparam int PHASE_ITEMS = 150;
	localparam int SETTLE_CYCLES = 2 * 64 + 12;
	localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint Q_MIN = -64'sh0000_0000_8000_0000;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
	} feed_word_t;

	typedef struct packed {
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic               result_last;
		logic               empty_stage;
		logic               truncated;
	} stage_word_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dcs_pt_if  pts_ch ();
	dcs_res_if res_ch ();

	de_casteljau_stage_points #(
		.MAX_POINTS  (STORE_DEPTH),
		.T_FRAC_BITS (T_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pts     (pts_ch),
		.res     (res_ch)
	);

	feed_word_t  point_feed[$];
	stage_word_t stage_words_due[$];

	// predictor state
	dcs_pkg::point_t             curve_pts[STORE_DEPTH];
	int unsigned                 pts_held;
	bit                          pts_dropped;
	logic [16:0]                 t_q;
	logic [dcs_pkg::STAGE_W-1:0] k_q;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int res_hold = 0;
	int errors = 0;
	int items_made = 0;

	function automatic longint lerp_q16(longint a, longint b);
		longint prod;
		longint r;
		prod = (b - a) * longint'(t_q);
		r = a + (prod >>> T_BITS);
		if (r > Q_MAX)
			r = Q_MAX;
		if (r < Q_MIN)
			r = Q_MIN;
		return r;
	endfunction

	function automatic void take_point(dcs_pkg::point_t p, logic last);
		stage_word_t w;
		longint      wx[STORE_DEPTH];
		longint      wy[STORE_DEPTH];
		int          base;
		bit          emit;
		w = '0;
		emit = 0;
		if (pts_held >= STORE_DEPTH) begin
			pts_dropped = 1;
			if (last) begin
				w.result_last = 1;
				w.truncated = 1;
				w.empty_stage = (STORE_DEPTH <= k_q);
				emit = 1;
			end
		end else begin
			curve_pts[pts_held] = p;
			pts_held++;
			if (pts_held - 1 >= k_q) begin
				base = pts_held - 1 - k_q;
				for (int m = 0; m <= k_q; m++) begin
					wx[m] = curve_pts[base + m].x;
					wy[m] = curve_pts[base + m].y;
				end
				for (int lv = 1; lv <= k_q; lv++) begin
					for (int m = 0; m + lv <= k_q; m++) begin
						wx[m] = lerp_q16(wx[m], wx[m + 1]);
						wy[m] = lerp_q16(wy[m], wy[m + 1]);
					end
				end
				w.qx = wx[0][31:0];
				w.qy = wy[0][31:0];
				w.result_last = last;
				w.truncated = pts_dropped;
				emit = 1;
			end else if (last) begin
				w.result_last = 1;
				w.empty_stage = 1;
				w.truncated = pts_dropped;
				emit = 1;
			end
		end
		if (emit)
			stage_words_due.push_back(w);
		if (last) begin
			pts_held = 0;
			pts_dropped = 0;
		end
	endfunction

	function automatic logic [31:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			2: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// point driver
	always @(posedge clk) begin : point_drive
		dcs_pkg::point_t p;
		feed_word_t      nxt;
		if (arst_n) begin
			if (pts_ch.valid && pts_ch.ready) begin
				p.x = pts_ch.px;
				p.y = pts_ch.py;
				take_point(p, pts_ch.point_last);
			end
			if (!pts_ch.valid || pts_ch.ready) begin
				if (point_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = point_feed.pop_front();
					pts_ch.valid <= 1'b1;
					pts_ch.px <= nxt.x;
					pts_ch.py <= nxt.y;
					pts_ch.point_last <= nxt.last;
				end else begin
					pts_ch.valid <= 1'b0;
				end
			end
		end
	end

	// stage word monitor
	always @(posedge clk) begin : word_check
		stage_word_t got;
		stage_word_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.qx = res_ch.qx;
				got.qy = res_ch.qy;
				got.result_last = res_ch.result_last;
				got.empty_stage = res_ch.empty_stage;
				got.truncated = res_ch.truncated;
				if (stage_words_due.size() == 0) begin
					$display("%0t: word with none due: qx=%h qy=%h last=%b empty=%b trunc=%b",
						$time, got.qx, got.qy, got.result_last, got.empty_stage,
						got.truncated);
					errors++;
				end else begin
					want = stage_words_due.pop_front();
					if (got !== want) begin
						$display("%0t: word expected qx=%h qy=%h last=%b empty=%b trunc=%b",
							$time, want.qx, want.qy, want.result_last, want.empty_stage,
							want.truncated);
						$display("%0t: word actual   qx=%h qy=%h last=%b empty=%b trunc=%b",
							$time, got.qx, got.qy, got.result_last, got.empty_stage,
							got.truncated);
						errors++;
					end
				end
			end
			if (res_hold > 0) begin
				res_hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic queue_point(logic [31:0] x, logic [31:0] y, logic last);
		feed_word_t f;
		f.x = x;
		f.y = y;
		f.last = last;
		point_feed.push_back(f);
		items_made++;
	endtask

	task automatic drain();
		while (point_feed.size() > 0 || pts_ch.valid || stage_words_due.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_check(logic [2:0] addr, logic [31:0] want);
		logic [31:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			$display("%0t: register at %0h expected %h actual %h", $time, addr, want, got);
			errors++;
		end
	endtask

	task automatic set_config(logic [31:0] t_raw, logic [31:0] k_raw);
		reg_write({dcs_pkg::REG_T_FRAC, 2'b00}, t_raw);
		reg_write({dcs_pkg::REG_STAGE, 2'b00}, k_raw);
		t_q = t_raw[16:0];
		k_q = k_raw[dcs_pkg::STAGE_W-1:0];
		reg_check({dcs_pkg::REG_T_FRAC, 2'b00}, {15'b0, t_q});
		reg_check({dcs_pkg::REG_STAGE, 2'b00}, {{(32 - dcs_pkg::STAGE_W){1'b0}}, k_q});
	endtask

	initial begin
		int          phase_items;
		int          len;
		int          pick;
		bit          close_set;
		logic [31:0] t_raw;
		logic [31:0] k_raw;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pts_ch.valid = 1'b0;
		pts_ch.px = '0;
		pts_ch.py = '0;
		pts_ch.point_last = 1'b0;
		res_ch.ready = 1'b0;
		pts_held = 0;
		pts_dropped = 0;
		t_q = '0;
		k_q = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: plain echo of the points
		queue_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		queue_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
		drain();

		// t = 1.0 and two stages, junk above both fields
		set_config(32'hFFFF_0000, 32'hFFFF_FFC2);
		queue_point(32'd5, 32'd6, 1'b1);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		drain();

		// t near 2.0 pushes the coordinates into saturation
		set_config(32'h0001_FFFF, 32'd1);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		drain();

		// one point more than the store holds
		set_config(32'h0000_8000, 32'd1);
		for (int i = 0; i <= STORE_DEPTH; i++)
			queue_point(random_coord(), random_coord(), i == STORE_DEPTH);

		for (int phase = 0; items_made < ITEM_TARGET; phase++) begin
			drain();
			@(negedge clk);
			case (phase % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 60; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 60; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			case (phase)
				0: begin t_raw = 32'h0; k_raw = 32'd63; end
				1: begin t_raw = 32'h0001_0000; k_raw = 32'd0; end
				2: begin t_raw = $urandom; k_raw = 32'd15; end
				3: begin t_raw = $urandom_range(32'h0001_0000); k_raw = 32'd16; end
				default: begin
					if ($urandom_range(3) == 0)
						t_raw = $urandom;
					else
						t_raw = ($urandom & ~32'h1_FFFF) | $urandom_range(32'h0001_0000);
					if ($urandom_range(9) < 7)
						k_raw = ($urandom & ~32'h3F) | $urandom_range(15);
					else
						k_raw = ($urandom & ~32'h3F) | $urandom_range(63, 16);
				end
			endcase
			set_config(t_raw, k_raw);
			@(negedge clk);
			// long receiver hold-off so the block backs up into its input
			if (phase == 4)
				res_hold = 400;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 15)
					len = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
				else if (k_q < STORE_DEPTH && pick < 80)
					len = $urandom_range(STORE_DEPTH, k_q + 1);
				else
					len = $urandom_range(STORE_DEPTH, 1);
				// an unterminated set runs on into the next one
				close_set = ($urandom_range(99) >= 8);
				for (int i = 0; i < len; i++)
					queue_point(random_coord(), random_coord(), close_set && i == len - 1);
				phase_items += len;
			end
		end
		drain();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
